// ===== hdl/lbrs_pkg.sv =====
// Shared types and constants for the LCD byte to RGB565 scaler.
// Depends on nothing; every other file of the block imports it.
`timescale 1ns / 1ps

package lbrs_pkg;

  // Default geometry of the emulated LCD picture.
  localparam int unsigned SRC_WIDTH_DEF   = 160;
  localparam int unsigned SRC_HEIGHT_DEF  = 80;
  localparam int unsigned PIXEL_SCALE_DEF = 2;

  // Port and datapath widths fixed by the field definitions.
  localparam int unsigned IDX_W    = 12;
  localparam int unsigned COLOR_W  = 16;
  localparam int unsigned SCR_W    = 10;
  localparam int unsigned STRIDE_W = 12;
  localparam int unsigned ADDR_W   = 22;
  localparam int unsigned DST_W    = 11;
  localparam int unsigned CFG_IDX_W = 4;
  localparam int unsigned CFG_DATA_W = 16;

  // Depth of the item queue between front and back end.
  localparam int unsigned QDEPTH = 4;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_GREY_MODE     = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PAL_WHITE     = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PAL_LIGHT     = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PAL_DARK      = 4'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PAL_BLACK     = 4'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_WIDTH  = 4'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_HEIGHT = 4'd6;
  localparam logic [CFG_IDX_W-1:0] REG_LINE_STRIDE   = 4'd7;

  // Reset values of the configuration registers.
  localparam logic [COLOR_W-1:0]  PAL_WHITE_RST = 16'hD6F4;
  localparam logic [COLOR_W-1:0]  PAL_LIGHT_RST = 16'h9D11;
  localparam logic [COLOR_W-1:0]  PAL_DARK_RST  = 16'h6B49;
  localparam logic [COLOR_W-1:0]  PAL_BLACK_RST = 16'h1861;
  localparam logic [SCR_W-1:0]    SCREEN_WIDTH_RST  = 10'd320;
  localparam logic [SCR_W-1:0]    SCREEN_HEIGHT_RST = 10'd170;
  localparam logic [STRIDE_W-1:0] LINE_STRIDE_RST   = 12'd640;

  // Palette entry selected by a set monochrome pixel.
  localparam logic [1:0] PAL_IDX_SET = 2'h3;

  // Index of the final pixel of a byte in each mode.
  localparam logic [2:0] PIX_LAST_MONO = 3'd7;
  localparam logic [2:0] PIX_LAST_GREY = 3'd3;

  // Configuration register contents seen by the datapath.
  typedef struct packed {
    logic                          grey_mode;
    logic [3:0][COLOR_W-1:0]       palette;
    logic [SCR_W-1:0]              disp_width;
    logic [SCR_W-1:0]              disp_height;
    logic [STRIDE_W-1:0]           line_stride;
  } cfg_t;

endpackage

// ===== hdl/lcd_byte_to_rgb565_scaler.sv =====
// Packed LCD byte to RGB565 scaler: one item in, up to 32 writes out.
// Path of an item: front stages, item queue, sequencer, output register.
// Throughput: one write per cycle while items are queued, so PPB*PIXEL_SCALE^2
// writes per item (32 monochrome, 16 grey at scale 2), set by the single write sequencer.
// Items are taken while earlier ones are still written; busy rises once the
// queue and the three-stage front pipeline together hold four items.
// Reset is async and returns the registers to their defaults.
`timescale 1ns / 1ps

module lcd_byte_to_rgb565_scaler #(
  parameter int unsigned SRC_WIDTH   = lbrs_pkg::SRC_WIDTH_DEF,
  parameter int unsigned SRC_HEIGHT  = lbrs_pkg::SRC_HEIGHT_DEF,
  parameter int unsigned PIXEL_SCALE = lbrs_pkg::PIXEL_SCALE_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start,
  output logic                            busy,
  input  logic [lbrs_pkg::IDX_W-1:0]      byte_index_i,
  input  logic [7:0]                      byte_value_i,
  input  logic                            blank_i,
  output logic                            strobe,
  output logic [lbrs_pkg::ADDR_W-1:0]     fb_byte_address_o,
  output logic [lbrs_pkg::COLOR_W-1:0]    color_o,
  output logic                            last_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [lbrs_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [lbrs_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import lbrs_pkg::*;

  localparam int unsigned X_W   = $clog2(SRC_WIDTH);
  localparam int unsigned Y_W   = $clog2(SRC_HEIGHT);
  localparam int unsigned ENT_W = Y_W + X_W + 8;
  localparam int unsigned CNT_W = $clog2(QDEPTH) + 1;

  cfg_t             cfg;
  logic             accept;
  logic             push, pop, q_empty;
  logic [ENT_W-1:0] push_data, q_head;
  logic [1:0]       inflight;
  logic [CNT_W-1:0] q_count;

  // Hold off new items once queue plus front pipeline could fill the queue.
  assign busy   = ((CNT_W+1)'(q_count) + (CNT_W+1)'(inflight)) >= (CNT_W+1)'(QDEPTH);
  assign accept = start && !busy;

  lbrs_regs u_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  lbrs_front #(
    .SRC_WIDTH  (SRC_WIDTH),
    .SRC_HEIGHT (SRC_HEIGHT),
    .X_W        (X_W),
    .Y_W        (Y_W)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .grey_mode_i  (cfg.grey_mode),
    .byte_index_i (byte_index_i),
    .byte_value_i (byte_value_i),
    .blank_i      (blank_i),
    .push_o       (push),
    .push_data_o  (push_data),
    .inflight_o   (inflight)
  );

  lbrs_queue #(
    .DATA_W (ENT_W),
    .DEPTH  (QDEPTH)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .head_o      (q_head),
    .empty_o     (q_empty),
    .count_o     (q_count)
  );

  lbrs_back #(
    .SRC_WIDTH   (SRC_WIDTH),
    .SRC_HEIGHT  (SRC_HEIGHT),
    .PIXEL_SCALE (PIXEL_SCALE),
    .X_W         (X_W),
    .Y_W         (Y_W)
  ) u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_i             (cfg),
    .q_empty_i         (q_empty),
    .q_head_i          (q_head),
    .q_pop_o           (pop),
    .strobe_o          (strobe),
    .fb_byte_address_o (fb_byte_address_o),
    .color_o           (color_o),
    .last_o            (last_o)
  );

endmodule

// ===== hdl/lbrs_regs.sv =====
// Configuration register file of the LCD byte to RGB565 scaler.
// Depends on lbrs_pkg for register indexes, reset values and cfg_t.
`timescale 1ns / 1ps

module lbrs_regs (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [lbrs_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [lbrs_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output lbrs_pkg::cfg_t                 cfg_o
);
  import lbrs_pkg::*;

  cfg_t cfg_q, cfg_d;
  logic wr_en;

  // Writes are always taken.
  assign cfg_ready_o = 1'b1;
  assign wr_en       = cfg_valid_i;

  // Decode the written register; unknown indexes leave everything alone.
  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (cfg_index_i)
        REG_GREY_MODE:     cfg_d.grey_mode   = cfg_data_i[0];
        REG_PAL_WHITE:     cfg_d.palette[0]  = cfg_data_i;
        REG_PAL_LIGHT:     cfg_d.palette[1]  = cfg_data_i;
        REG_PAL_DARK:      cfg_d.palette[2]  = cfg_data_i;
        REG_PAL_BLACK:     cfg_d.palette[3]  = cfg_data_i;
        REG_SCREEN_WIDTH:  cfg_d.disp_width  = cfg_data_i[SCR_W-1:0];
        REG_SCREEN_HEIGHT: cfg_d.disp_height = cfg_data_i[SCR_W-1:0];
        REG_LINE_STRIDE:   cfg_d.line_stride = cfg_data_i[STRIDE_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.grey_mode   <= 1'b0;
      cfg_q.palette[0]  <= PAL_WHITE_RST;
      cfg_q.palette[1]  <= PAL_LIGHT_RST;
      cfg_q.palette[2]  <= PAL_DARK_RST;
      cfg_q.palette[3]  <= PAL_BLACK_RST;
      cfg_q.disp_width  <= SCREEN_WIDTH_RST;
      cfg_q.disp_height <= SCREEN_HEIGHT_RST;
      cfg_q.line_stride <= LINE_STRIDE_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== hdl/lbrs_front.sv =====
// Front end of the scaler: range check, blanking and the split of the
// first pixel position into source row and column. Depends on lbrs_pkg.
`timescale 1ns / 1ps

module lbrs_front #(
  parameter int unsigned SRC_WIDTH  = lbrs_pkg::SRC_WIDTH_DEF,
  parameter int unsigned SRC_HEIGHT = lbrs_pkg::SRC_HEIGHT_DEF,
  parameter int unsigned X_W        = $clog2(SRC_WIDTH),
  parameter int unsigned Y_W        = $clog2(SRC_HEIGHT)
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       accept_i,
  input  logic                       grey_mode_i,
  input  logic [lbrs_pkg::IDX_W-1:0] byte_index_i,
  input  logic [7:0]                 byte_value_i,
  input  logic                       blank_i,
  output logic                       push_o,
  output logic [Y_W+X_W+7:0]         push_data_o,
  output logic [1:0]                 inflight_o
);
  import lbrs_pkg::*;

  localparam int unsigned TOTAL    = SRC_WIDTH * SRC_HEIGHT;
  localparam int unsigned POS_W    = $clog2(TOTAL);
  localparam int unsigned LIM_MONO = TOTAL / 8;
  localparam int unsigned LIM_GREY = TOTAL / 4;
  // Reciprocal of the row length, rounded down, for the quotient estimate.
  localparam int unsigned DIV_SH   = POS_W + 10;
  localparam int unsigned RECIP_W  = DIV_SH - 2;
  localparam longint unsigned RECIP_VAL = (64'd1 << DIV_SH) / SRC_WIDTH;
  localparam logic [RECIP_W-1:0] RECIP  = RECIP_W'(RECIP_VAL);
  localparam int unsigned PROD_W   = POS_W + RECIP_W;

  logic                 in_range;
  logic [IDX_W+2:0]     pos_full;

  logic                 v1_q, v2_q, v3_q;
  logic [POS_W-1:0]     pos1_q, pos2_q;
  logic [7:0]           byte1_q, byte2_q, byte3_q;
  logic [PROD_W-1:0]    prod2_q;
  logic [Y_W-1:0]       q3_q, q_est;
  logic [X_W:0]         rem3_q;
  logic [POS_W-1:0]     rem_full;
  logic [Y_W-1:0]       row_y;
  logic [X_W-1:0]       row_x;

  // Range check against the packed buffer size of the current mode.
  assign in_range = grey_mode_i ? (32'(byte_index_i) < 32'(LIM_GREY))
                                : (32'(byte_index_i) < 32'(LIM_MONO));
  assign pos_full = grey_mode_i ? {1'b0, byte_index_i, 2'b00} : {byte_index_i, 3'b000};

  // Valid bits of the three pipeline stages.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= accept_i && in_range;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  // Quotient estimate from the reciprocal, remainder after that estimate.
  assign q_est    = prod2_q[DIV_SH +: Y_W];
  assign rem_full = pos2_q - POS_W'(POS_W'(q_est) * POS_W'(SRC_WIDTH));

  always_ff @(posedge clk_i) begin
    pos1_q  <= POS_W'(pos_full);
    byte1_q <= blank_i ? 8'h00 : byte_value_i;
    prod2_q <= PROD_W'(pos1_q) * PROD_W'(RECIP);
    pos2_q  <= pos1_q;
    byte2_q <= byte1_q;
    q3_q    <= q_est;
    rem3_q  <= rem_full[X_W:0];
    byte3_q <= byte2_q;
  end

  // The estimate is low by at most one row; correct it here.
  always_comb begin
    if (rem3_q >= (X_W+1)'(SRC_WIDTH)) begin
      row_y = q3_q + Y_W'(1);
      row_x = X_W'(rem3_q - (X_W+1)'(SRC_WIDTH));
    end else begin
      row_y = q3_q;
      row_x = rem3_q[X_W-1:0];
    end
  end

  assign push_o      = v3_q;
  assign push_data_o = {row_y, row_x, byte3_q};
  assign inflight_o  = 2'(v1_q) + 2'(v2_q) + 2'(v3_q);

endmodule

// ===== hdl/lbrs_queue.sv =====
// Small item queue between front and back end of the scaler.
// Depends on lbrs_pkg for the default queue depth.
`timescale 1ns / 1ps

module lbrs_queue #(
  parameter int unsigned DATA_W = 8,
  parameter int unsigned DEPTH  = lbrs_pkg::QDEPTH
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       push_i,
  input  logic [DATA_W-1:0]          push_data_i,
  input  logic                       pop_i,
  output logic [DATA_W-1:0]          head_o,
  output logic                       empty_o,
  output logic [$clog2(DEPTH):0]     count_o
);
  import lbrs_pkg::*;

  localparam int unsigned PTR_W = $clog2(DEPTH);

  logic [DATA_W-1:0] slot_q [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_q, rd_ptr_q;
  logic [PTR_W:0]    count_q, count_d;

  // Pointer and fill tracking.
  always_comb begin
    count_d = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + (PTR_W+1)'(1);
    end else if (pop_i && !push_i) begin
      count_d = count_q - (PTR_W+1)'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) wr_ptr_q <= wr_ptr_q + PTR_W'(1);
      if (pop_i)  rd_ptr_q <= rd_ptr_q + PTR_W'(1);
      count_q <= count_d;
    end
  end

  // Storage slots.
  always_ff @(posedge clk_i) begin
    if (push_i) slot_q[wr_ptr_q] <= push_data_i;
  end

  assign head_o  = slot_q[rd_ptr_q];
  assign empty_o = (count_q == '0);
  assign count_o = count_q;

  // The front end must never push into a full queue.
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i && !pop_i && count_q == (PTR_W+1)'(DEPTH)))
    else $error("item queue overflow");

  // The back end must never pop an empty queue.
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(pop_i && empty_o))
    else $error("item queue underflow");

endmodule

// ===== hdl/lbrs_back.sv =====
// Back end of the scaler: walks the pixels and replicas of one item and
// emits one framebuffer write per cycle while it holds an item. Depends on lbrs_pkg.
`timescale 1ns / 1ps

module lbrs_back #(
  parameter int unsigned SRC_WIDTH   = lbrs_pkg::SRC_WIDTH_DEF,
  parameter int unsigned SRC_HEIGHT  = lbrs_pkg::SRC_HEIGHT_DEF,
  parameter int unsigned PIXEL_SCALE = lbrs_pkg::PIXEL_SCALE_DEF,
  parameter int unsigned X_W         = $clog2(SRC_WIDTH),
  parameter int unsigned Y_W         = $clog2(SRC_HEIGHT)
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  lbrs_pkg::cfg_t              cfg_i,
  input  logic                        q_empty_i,
  input  logic [Y_W+X_W+7:0]          q_head_i,
  output logic                        q_pop_o,
  output logic                        strobe_o,
  output logic [lbrs_pkg::ADDR_W-1:0] fb_byte_address_o,
  output logic [lbrs_pkg::COLOR_W-1:0] color_o,
  output logic                        last_o
);
  import lbrs_pkg::*;

  localparam int unsigned REP_W = (PIXEL_SCALE > 1) ? $clog2(PIXEL_SCALE) : 1;
  localparam logic [REP_W-1:0] REP_LAST = REP_W'(PIXEL_SCALE - 1);
  localparam logic [DST_W-1:0] PIC_W = DST_W'(SRC_WIDTH * PIXEL_SCALE);
  localparam logic [DST_W-1:0] PIC_H = DST_W'(SRC_HEIGHT * PIXEL_SCALE);
  localparam int unsigned PROD_W = DST_W + STRIDE_W;

  logic             active_q;
  logic [7:0]       byte_q;
  logic [X_W-1:0]   x_q;
  logic [Y_W-1:0]   y_q;
  logic [2:0]       pix_q;
  logic [REP_W-1:0] sx_q, sy_q;

  logic [DST_W-1:0] scr_w, scr_h, off_x, off_y, dst_x, dst_y;
  logic [1:0]       pal_idx;
  logic [2:0]       pix_last;
  logic             last_now;
  logic [PROD_W-1:0] addr_full;

  logic              strobe_q, last_q;
  logic [ADDR_W-1:0] addr_q;
  logic [COLOR_W-1:0] color_q;

  // Centring offsets, clamped at zero.
  assign scr_w = DST_W'(cfg_i.disp_width);
  assign scr_h = DST_W'(cfg_i.disp_height);
  assign off_x = (scr_w > PIC_W) ? ((scr_w - PIC_W) >> 1) : '0;
  assign off_y = (scr_h > PIC_H) ? ((scr_h - PIC_H) >> 1) : '0;

  // Current pixel value, most significant pixel first.
  assign pal_idx  = cfg_i.grey_mode ? byte_q[7:6] : (byte_q[7] ? PAL_IDX_SET : 2'b00);
  assign pix_last = cfg_i.grey_mode ? PIX_LAST_GREY : PIX_LAST_MONO;
  assign last_now = active_q && (pix_q == pix_last) && (sx_q == REP_LAST)
                    && (sy_q == REP_LAST);
  assign q_pop_o  = !q_empty_i && (!active_q || last_now);

  // Destination address of the current replica.
  assign dst_x = off_x + DST_W'(DST_W'(x_q) * DST_W'(PIXEL_SCALE)) + DST_W'(sx_q);
  assign dst_y = off_y + DST_W'(DST_W'(y_q) * DST_W'(PIXEL_SCALE)) + DST_W'(sy_q);
  assign addr_full = PROD_W'(dst_y) * PROD_W'(cfg_i.line_stride)
                     + PROD_W'({dst_x, 1'b0});

  // Item sequencer: replica column, replica row, then next pixel.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      pix_q    <= '0;
      sx_q     <= '0;
      sy_q     <= '0;
    end else if (q_pop_o) begin
      active_q <= 1'b1;
      pix_q    <= '0;
      sx_q     <= '0;
      sy_q     <= '0;
    end else if (active_q) begin
      if (last_now) begin
        active_q <= 1'b0;
      end else if (sx_q != REP_LAST) begin
        sx_q <= sx_q + REP_W'(1);
      end else if (sy_q != REP_LAST) begin
        sx_q <= '0;
        sy_q <= sy_q + REP_W'(1);
      end else begin
        sx_q  <= '0;
        sy_q  <= '0;
        pix_q <= pix_q + 3'd1;
      end
    end
  end

  // Pixel payload: byte shifter and source position with row wrap.
  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      y_q    <= q_head_i[X_W+8 +: Y_W];
      x_q    <= q_head_i[8 +: X_W];
      byte_q <= q_head_i[7:0];
    end else if (active_q && sx_q == REP_LAST && sy_q == REP_LAST) begin
      byte_q <= cfg_i.grey_mode ? {byte_q[5:0], 2'b00} : {byte_q[6:0], 1'b0};
      if (x_q == X_W'(SRC_WIDTH - 1)) begin
        x_q <= '0;
        y_q <= y_q + Y_W'(1);
      end else begin
        x_q <= x_q + X_W'(1);
      end
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      strobe_q <= 1'b0;
      last_q   <= 1'b0;
    end else begin
      strobe_q <= active_q;
      last_q   <= last_now;
    end
  end

  always_ff @(posedge clk_i) begin
    addr_q  <= addr_full[ADDR_W-1:0];
    color_q <= cfg_i.palette[pal_idx];
  end

  assign strobe_o          = strobe_q;
  assign last_o            = last_q;
  assign fb_byte_address_o = addr_q;
  assign color_o           = color_q;

  // The final write flag only comes with a write.
  a_last_has_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    last_o |-> strobe_o)
    else $error("last without strobe");

  // Writes of one item come in an unbroken run up to the final one.
  a_run_unbroken: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (strobe_o && !last_o) |=> strobe_o)
    else $error("gap inside an item's writes");

endmodule
